[rtl/gradient_line_pixel_generator_macros.svh]
// Assertion helpers for the gradient line pixel generator.
`ifndef GRADIENT_LINE_PIXEL_GENERATOR_MACROS_SVH
`define GRADIENT_LINE_PIXEL_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define GLPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define GLPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GLPG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GLPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/glpg_pkg.sv]
`timescale 1ns / 1ps
package glpg_pkg;

  localparam int COORD_BITS_DEF   = 10;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int NUM_CHANNELS     = 3;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic adv;
    logic div_step;
    logic div_fix;
  } dp_cmd_t;

  typedef struct packed {
    logic line_active;
  } dp_status_t;

endpackage

[rtl/gradient_line_pixel_generator.sv]
// A pixel beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: advance requests run at one per cycle while no pending pixel beat
// is held by an output stall. After a start the input stalls while the
// per-channel colour step is divided by the line length, one quotient bit per cycle.
// Reset (async, active low): no line active, no pixel beat pending.
`timescale 1ns / 1ps
`include "gradient_line_pixel_generator_macros.svh"
module gradient_line_pixel_generator import glpg_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    req_type_i,
  input  logic [COORD_BITS-1:0]   start_x_i,
  input  logic [COORD_BITS-1:0]   start_y_i,
  input  logic [COORD_BITS-1:0]   end_x_i,
  input  logic [COORD_BITS-1:0]   end_y_i,
  input  logic [CHANNEL_BITS-1:0] start_red_i,
  input  logic [CHANNEL_BITS-1:0] start_green_i,
  input  logic [CHANNEL_BITS-1:0] start_blue_i,
  input  logic [CHANNEL_BITS-1:0] end_red_i,
  input  logic [CHANNEL_BITS-1:0] end_green_i,
  input  logic [CHANNEL_BITS-1:0] end_blue_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COORD_BITS-1:0]   pixel_x_o,
  output logic [COORD_BITS-1:0]   pixel_y_o,
  output logic [CHANNEL_BITS-1:0] pixel_red_o,
  output logic [CHANNEL_BITS-1:0] pixel_green_o,
  output logic [CHANNEL_BITS-1:0] pixel_blue_o,
  output logic                    last_pixel_o
);

  dp_cmd_t                                  cmd;
  dp_status_t                               status;
  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] start_colour, end_colour, pixel_colour;

  assign start_colour = {start_blue_i, start_green_i, start_red_i};
  assign end_colour   = {end_blue_i, end_green_i, end_red_i};

  glpg_ctrl #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  glpg_datapath #(
    .COORD_BITS  (COORD_BITS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .start_colour_i (start_colour),
    .end_colour_i   (end_colour),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_colour_o (pixel_colour),
    .last_pixel_o   (last_pixel_o)
  );

  assign pixel_red_o   = pixel_colour[0];
  assign pixel_green_o = pixel_colour[1];
  assign pixel_blue_o  = pixel_colour[2];

  `GLPG_ASSERT_NEXT(a_start_emits, clk_i, rst_ni, cmd.start, out_valid_o)
  `GLPG_ASSERT_SAME(a_div_stalls, clk_i, rst_ni, cmd.div_step || cmd.div_fix, in_stall_o)
  `GLPG_ASSERT_SAME(a_last_ends_line, clk_i, rst_ni, out_valid_o && last_pixel_o, !status.line_active)

endmodule

[rtl/glpg_ctrl.sv]
`timescale 1ns / 1ps
module glpg_ctrl import glpg_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int CNT_W = $clog2(CHANNEL_BITS);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CHANNEL_BITS - 1)) begin
          state_d = ST_FIX;
          cnt_d   = '0;
        end
      end
      ST_FIX: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
    accept          = in_valid_i && !in_stall_o;
    cmd_o.start     = accept && (req_type_i == REQ_START);
    cmd_o.adv       = accept && (req_type_i == REQ_ADVANCE) && status_i.line_active;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.div_fix   = (state_q == ST_FIX);
    if (cmd_o.start || cmd_o.adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/glpg_datapath.sv]
`timescale 1ns / 1ps
module glpg_datapath import glpg_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  dp_cmd_t                                    cmd_i,
  output dp_status_t                                 status_o,
  input  logic [COORD_BITS-1:0]                      start_x_i,
  input  logic [COORD_BITS-1:0]                      start_y_i,
  input  logic [COORD_BITS-1:0]                      end_x_i,
  input  logic [COORD_BITS-1:0]                      end_y_i,
  input  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0]  start_colour_i,
  input  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0]  end_colour_i,
  output logic [COORD_BITS-1:0]                      pixel_x_o,
  output logic [COORD_BITS-1:0]                      pixel_y_o,
  output logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0]  pixel_colour_o,
  output logic                                       last_pixel_o
);

  localparam int CW  = COORD_BITS;
  localparam int KW  = CHANNEL_BITS;
  localparam int EW  = CW + 2;
  localparam int E2W = CW + 3;
  localparam int DQW = KW + 1;
  localparam int QSW = KW + 2;

  // line state
  logic                  line_active_q;
  logic [CW-1:0]         cur_col_q, cur_row_q;
  logic [CW-1:0]         span_x_q, span_y_q;
  logic                  dir_x_neg_q, dir_y_neg_q;
  logic signed [EW-1:0]  err_q;
  logic [CW-1:0]         idx_q, len_q;

  // per-channel colour stepping and division
  logic [KW-1:0]         q_q       [NUM_CHANNELS];
  logic [CW-1:0]         r_q       [NUM_CHANNELS];
  logic signed [DQW-1:0] dq_q      [NUM_CHANNELS];
  logic [CW-1:0]         dr_q      [NUM_CHANNELS];
  logic                  neg_q     [NUM_CHANNELS];
  logic [KW-1:0]         div_num_q [NUM_CHANNELS];
  logic [CW-1:0]         div_rem_q [NUM_CHANNELS];
  logic [KW-1:0]         div_quo_q [NUM_CHANNELS];

  // output beat
  logic [CW-1:0]                     pix_x_q, pix_y_q;
  logic [NUM_CHANNELS-1:0][KW-1:0]   pix_col_q;
  logic                              last_q;

  // start decode
  logic [CW-1:0] sx_s, sy_s, len_s;
  logic          dxn_s, dyn_s;

  // advance step
  logic signed [E2W-1:0] e2_s, sx_e2, sy_e2;
  logic signed [EW-1:0]  sx_e, sy_e, err_nxt;
  logic                  step_x, step_y;
  logic [CW-1:0]         col_nxt, row_nxt, idx_nxt;
  logic                  last_nxt;

  logic [CW:0]           r_sum   [NUM_CHANNELS];
  logic [CW:0]           r_sub   [NUM_CHANNELS];
  logic                  carry   [NUM_CHANNELS];
  logic [CW-1:0]         r_nxt   [NUM_CHANNELS];
  logic signed [QSW-1:0] q_sum   [NUM_CHANNELS];
  logic [KW-1:0]         q_nxt   [NUM_CHANNELS];

  logic [KW-1:0]         mag_s   [NUM_CHANNELS];
  logic                  neg_s   [NUM_CHANNELS];
  logic [CW:0]           trial   [NUM_CHANNELS];
  logic [CW:0]           diff    [NUM_CHANNELS];
  logic                  ge      [NUM_CHANNELS];
  logic [CW-1:0]         rem_nxt [NUM_CHANNELS];
  logic signed [DQW-1:0] quo_ext [NUM_CHANNELS];
  logic signed [DQW-1:0] dq_fix  [NUM_CHANNELS];
  logic [CW-1:0]         dr_fix  [NUM_CHANNELS];

  always_comb begin
    sx_s  = (end_x_i >= start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
    sy_s  = (end_y_i >= start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
    len_s = (sx_s > sy_s) ? sx_s : sy_s;
    dxn_s = !(start_x_i < end_x_i);
    dyn_s = !(start_y_i < end_y_i);
  end

  always_comb begin
    e2_s   = $signed({err_q, 1'b0});
    sx_e2  = $signed({3'b000, span_x_q});
    sy_e2  = $signed({3'b000, span_y_q});
    sx_e   = $signed({2'b00, span_x_q});
    sy_e   = $signed({2'b00, span_y_q});
    step_x = (e2_s > -sy_e2);
    step_y = (e2_s < sx_e2);
    err_nxt = err_q;
    col_nxt = cur_col_q;
    row_nxt = cur_row_q;
    if (step_x) begin
      err_nxt = err_nxt - sy_e;
      col_nxt = dir_x_neg_q ? cur_col_q - 1'b1 : cur_col_q + 1'b1;
    end
    if (step_y) begin
      err_nxt = err_nxt + sx_e;
      row_nxt = dir_y_neg_q ? cur_row_q - 1'b1 : cur_row_q + 1'b1;
    end
    idx_nxt  = idx_q + 1'b1;
    last_nxt = (idx_nxt >= len_q);
  end

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      r_sum[k] = {1'b0, r_q[k]} + {1'b0, dr_q[k]};
      r_sub[k] = r_sum[k] - {1'b0, len_q};
      carry[k] = (r_sum[k] >= {1'b0, len_q});
      r_nxt[k] = carry[k] ? r_sub[k][CW-1:0] : r_sum[k][CW-1:0];
      q_sum[k] = $signed({2'b00, q_q[k]}) + $signed({dq_q[k][DQW-1], dq_q[k]})
               + $signed({{(QSW-1){1'b0}}, carry[k]});
      q_nxt[k] = q_sum[k][KW-1:0];

      neg_s[k] = (end_colour_i[k] < start_colour_i[k]);
      mag_s[k] = neg_s[k] ? start_colour_i[k] - end_colour_i[k]
                          : end_colour_i[k] - start_colour_i[k];

      trial[k]   = {div_rem_q[k], div_num_q[k][KW-1]};
      diff[k]    = trial[k] - {1'b0, len_q};
      ge[k]      = (trial[k] >= {1'b0, len_q});
      rem_nxt[k] = ge[k] ? diff[k][CW-1:0] : trial[k][CW-1:0];

      quo_ext[k] = $signed({1'b0, div_quo_q[k]});
      if (!neg_q[k]) begin
        dq_fix[k] = quo_ext[k];
        dr_fix[k] = div_rem_q[k];
      end else if (div_rem_q[k] == '0) begin
        dq_fix[k] = -quo_ext[k];
        dr_fix[k] = '0;
      end else begin
        dq_fix[k] = ~quo_ext[k];
        dr_fix[k] = len_q - div_rem_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
    end else if (cmd_i.start) begin
      line_active_q <= (len_s != '0);
    end else if (cmd_i.adv) begin
      line_active_q <= !last_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_col_q   <= start_x_i;
      cur_row_q   <= start_y_i;
      span_x_q    <= sx_s;
      span_y_q    <= sy_s;
      dir_x_neg_q <= dxn_s;
      dir_y_neg_q <= dyn_s;
      err_q       <= $signed({2'b00, sx_s}) - $signed({2'b00, sy_s});
      idx_q       <= '0;
      len_q       <= len_s;
      pix_x_q     <= start_x_i;
      pix_y_q     <= start_y_i;
      last_q      <= (len_s == '0);
    end else if (cmd_i.adv) begin
      cur_col_q <= col_nxt;
      cur_row_q <= row_nxt;
      err_q     <= err_nxt;
      idx_q     <= idx_nxt;
      pix_x_q   <= col_nxt;
      pix_y_q   <= row_nxt;
      last_q    <= last_nxt;
    end
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (cmd_i.start) begin
        q_q[k]       <= start_colour_i[k];
        r_q[k]       <= '0;
        neg_q[k]     <= neg_s[k];
        div_num_q[k] <= mag_s[k];
        div_rem_q[k] <= '0;
        div_quo_q[k] <= '0;
        pix_col_q[k] <= start_colour_i[k];
      end else if (cmd_i.div_step) begin
        div_num_q[k] <= {div_num_q[k][KW-2:0], 1'b0};
        div_rem_q[k] <= rem_nxt[k];
        div_quo_q[k] <= {div_quo_q[k][KW-2:0], ge[k]};
      end else if (cmd_i.div_fix) begin
        dq_q[k] <= dq_fix[k];
        dr_q[k] <= dr_fix[k];
      end else if (cmd_i.adv) begin
        q_q[k]       <= q_nxt[k];
        r_q[k]       <= r_nxt[k];
        pix_col_q[k] <= q_nxt[k];
      end
    end
  end

  assign status_o.line_active = line_active_q;
  assign pixel_x_o            = pix_x_q;
  assign pixel_y_o            = pix_y_q;
  assign pixel_colour_o       = pix_col_q;
  assign last_pixel_o         = last_q;

endmodule
